// File: design/ostsb_pkg.sv
// Shared constants, codes and types of the one-shot timer slot bank.
package ostsb_pkg;

    localparam int SLOT_COUNT_DEF     = 4;
    localparam int TICK_PERIOD_MS_DEF = 1;

    localparam int ID_W     = 8;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 32;

    localparam logic [COUNT_W-1:0] FREE_MARK = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

    // radix-16 divider: one quotient digit per cycle
    localparam int DIGIT_W   = 4;
    localparam int DIV_STEPS = PERIOD_W / DIGIT_W;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_REG      = 1'b1;
    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_STATUS = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REFUSED  = 1'b1;

    // token walking down the chain of slot cells
    typedef struct packed {
        logic valid;
        logic done;     // a slot has already taken the register request
    } t_tok;

    // request fields seen by every cell
    typedef struct packed {
        logic               op;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic               any_match;
    } t_bcast;

    // per-cell flags read by the controller
    typedef struct packed {
        logic match;
        logic expiring;
    } t_cell_stat;

endpackage

// File: design/ostsb_div.sv
// Iterative radix-16 divider turning a period in ms into a saturated tick count.
module ostsb_div #(
    parameter int TICK_PERIOD_MS = ostsb_pkg::TICK_PERIOD_MS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ostsb_pkg::PERIOD_W-1:0]   i_period,
    output logic                             o_done,
    output logic [ostsb_pkg::COUNT_W-1:0]    o_ticks
);

    localparam int RW   = $clog2(TICK_PERIOD_MS + 1);
    localparam int PW   = RW + ostsb_pkg::DIGIT_W;
    localparam int SW   = $clog2(ostsb_pkg::DIV_STEPS);
    localparam int NDIG = (1 << ostsb_pkg::DIGIT_W) - 1;

    logic                            r_busy;
    logic                            r_done;
    logic [SW-1:0]                   r_step;
    logic [ostsb_pkg::PERIOD_W-1:0]  r_dvd;
    logic [ostsb_pkg::PERIOD_W-1:0]  r_quo;
    logic [RW-1:0]                   r_rem;

    logic [PW-1:0]                   part;
    logic [PW-1:0]                   sub;
    logic [ostsb_pkg::DIGIT_W-1:0]   digit;

    // pick the largest multiple of the tick period that fits the partial remainder
    always_comb begin
        part  = {r_rem, r_dvd[ostsb_pkg::PERIOD_W-1 -: ostsb_pkg::DIGIT_W]};
        digit = '0;
        sub   = '0;
        for (int k = 1; k <= NDIG; k++) begin
            if (part >= PW'(k * TICK_PERIOD_MS)) begin
                digit = ostsb_pkg::DIGIT_W'(k);
                sub   = PW'(k * TICK_PERIOD_MS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(ostsb_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_period;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << ostsb_pkg::DIGIT_W;
            r_quo <= {r_quo[ostsb_pkg::PERIOD_W-ostsb_pkg::DIGIT_W-1:0], digit};
            r_rem <= RW'(part - sub);
        end
    end

    assign o_done  = r_done;
    assign o_ticks = r_quo[ostsb_pkg::PERIOD_W-1] ? ostsb_pkg::COUNT_MAX
                                                  : ostsb_pkg::COUNT_W'(r_quo);

endmodule

// File: design/ostsb_cell.sv
// One timer slot: owner id and count, acting when the token passes through.
module ostsb_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ostsb_pkg::t_bcast             i_bc,
    input  ostsb_pkg::t_tok               i_tok,
    output ostsb_pkg::t_tok               o_tok,
    output ostsb_pkg::t_cell_stat         o_stat,
    output logic                          o_evt_valid,
    output logic [ostsb_pkg::ID_W-1:0]    o_evt_id
);

    logic [ostsb_pkg::ID_W-1:0]    r_owner;
    logic [ostsb_pkg::COUNT_W-1:0] r_count;
    ostsb_pkg::t_tok               r_tok;

    logic is_free;
    logic running;
    logic expiring;
    logic match;
    logic act;
    logic take;

    always_comb begin
        is_free  = (r_count == ostsb_pkg::FREE_MARK);
        running  = !r_count[ostsb_pkg::COUNT_W-1] && (r_count != '0);
        expiring = (r_count == ostsb_pkg::COUNT_W'(1));
        match    = (r_owner == i_bc.id);
        act      = i_en && i_tok.valid;
        // reload an owned slot if any exists, else claim the first free one
        take     = (i_bc.op == ostsb_pkg::OP_REG) && !i_tok.done
                   && (i_bc.id != '0) && (i_bc.any_match ? match : is_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_count <= ostsb_pkg::FREE_MARK;
            r_tok   <= '0;
        end else if (i_en) begin
            r_tok.valid <= i_tok.valid;
            r_tok.done  <= i_tok.done | take;
            if (act) begin
                if (take) begin
                    r_owner <= i_bc.id;
                    r_count <= i_bc.count;
                end else if (i_bc.op == ostsb_pkg::OP_TICK && running) begin
                    if (expiring) begin
                        r_owner <= '0;
                        r_count <= ostsb_pkg::FREE_MARK;
                    end else begin
                        r_count <= r_count - ostsb_pkg::COUNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_tok           = r_tok;
    assign o_stat.match    = match;
    assign o_stat.expiring = expiring;
    assign o_evt_valid     = act && (i_bc.op == ostsb_pkg::OP_TICK) && expiring;
    assign o_evt_id        = r_owner;

endmodule

// File: design/one_shot_timer_slot_bank_core.sv
// Top level of the one-shot timer slot bank: controller, slot chain and result register.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries one beat per item:
// i_op = 0 is a base tick, i_op = 1 registers or reloads callback i_callback_id
// with a delay of i_period_ms. The output channel (o_out_valid / i_out_stall)
// carries result beats: o_kind = 1 is the status of a register item (always
// o_last = 1), o_kind = 0 an expiry notice for o_fired_id, given in slot order,
// with o_last on the final notice of that tick. A tick that expires nothing
// gives no beat.
// Timing. One item is worked on at a time; o_in_stall is high from acceptance
// until the item is finished. A token walks the slot chain one cell per cycle
// while the result register can take a beat. A register item first runs the
// radix-16 divider (8 digit steps) and then the walk and the status beat.
// Each cell step moves into the result register, so the walk pauses while a
// result beat is held by i_out_stall; at most one expiry leaves per cycle.
// Reset. Synchronous, active low: all slots free (count all ones, owner zero),
// no result pending; the block accepts an item on the first cycle after reset.
module one_shot_timer_slot_bank_core #(
    parameter int SLOT_COUNT     = ostsb_pkg::SLOT_COUNT_DEF,
    parameter int TICK_PERIOD_MS = ostsb_pkg::TICK_PERIOD_MS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [ostsb_pkg::ID_W-1:0]      i_callback_id,
    input  logic [ostsb_pkg::PERIOD_W-1:0]  i_period_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kind,
    output logic [ostsb_pkg::ID_W-1:0]      o_fired_id,
    output logic                            o_status,
    output logic                            o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_LAUNCH,
        S_SWEEP,
        S_REPLY
    } t_state;

    t_state                          r_state;
    logic                            r_op;
    logic [ostsb_pkg::ID_W-1:0]      r_id;
    logic                            r_any_match;
    logic [SLOT_COUNT-1:0]           r_mask;
    logic                            r_status;

    logic                            r_out_valid;
    logic                            r_out_kind;
    logic [ostsb_pkg::ID_W-1:0]      r_out_id;
    logic                            r_out_status;
    logic                            r_out_last;

    logic                            accept;
    logic                            en;
    logic                            launch;
    logic                            div_done;
    logic [ostsb_pkg::COUNT_W-1:0]   div_ticks;
    ostsb_pkg::t_bcast               bc;
    ostsb_pkg::t_tok                 tok [SLOT_COUNT+1];
    ostsb_pkg::t_cell_stat           stat [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]           evt_valid;
    logic [ostsb_pkg::ID_W-1:0]      evt_id [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]           match_vec;
    logic [SLOT_COUNT-1:0]           exp_vec;
    logic [SLOT_COUNT-1:0]           tok_vec;
    logic                            evt_any;
    logic [ostsb_pkg::ID_W-1:0]      evt_sel;

    // hold the input while an item is in flight
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // the chain advances only when the result register can take a beat
    assign en     = !r_out_valid || !i_out_stall;
    assign launch = (r_state == S_LAUNCH) && en;

    assign bc.op        = r_op;
    assign bc.id        = r_id;
    assign bc.count     = div_ticks;
    assign bc.any_match = r_any_match;

    assign tok[0].valid = launch;
    assign tok[0].done  = 1'b0;

    ostsb_div #(
        .TICK_PERIOD_MS (TICK_PERIOD_MS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && (i_op == ostsb_pkg::OP_REG)),
        .i_period (i_period_ms),
        .o_done   (div_done),
        .o_ticks  (div_ticks)
    );

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        ostsb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_bc        (bc),
            .i_tok       (tok[g]),
            .o_tok       (tok[g+1]),
            .o_stat      (stat[g]),
            .o_evt_valid (evt_valid[g]),
            .o_evt_id    (evt_id[g])
        );
        assign match_vec[g] = stat[g].match;
        assign exp_vec[g]   = stat[g].expiring;
        assign tok_vec[g]   = tok[g].valid;
    end

    // only the cell holding the token can raise an event, so merge by OR
    always_comb begin
        evt_any = |evt_valid;
        evt_sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            evt_sel = evt_sel | (evt_valid[i] ? evt_id[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load on a push, drop once taken
            if (evt_any) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= ostsb_pkg::KIND_EXPIRY;
                r_out_id     <= evt_sel;
                r_out_status <= ostsb_pkg::ST_OK;
                r_out_last   <= ((r_mask >> 1) == '0);
            end else if (r_state == S_REPLY && en) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= ostsb_pkg::KIND_STATUS;
                r_out_id     <= '0;
                r_out_status <= r_status;
                r_out_last   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_op;
                        r_id    <= i_callback_id;
                        r_state <= (i_op == ostsb_pkg::OP_REG) ? S_DIV : S_PREP;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // snapshot slot flags before any cell changes
                    r_any_match <= |match_vec;
                    r_mask      <= exp_vec;
                    r_state     <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    if (en) begin
                        r_mask  <= r_mask >> 1;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (en) begin
                        r_mask <= r_mask >> 1;
                    end
                    if (tok[SLOT_COUNT].valid) begin
                        r_status <= tok[SLOT_COUNT].done ? ostsb_pkg::ST_OK
                                                         : ostsb_pkg::ST_REFUSED;
                        r_state  <= (r_op == ostsb_pkg::OP_REG) ? S_REPLY : S_IDLE;
                    end
                end
                S_REPLY: begin
                    if (en) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_fired_id  = r_out_id;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    // at most one token inside the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the slot chain");

    // expiry events only during a tick walk and only when the result register can take a beat
    a_evt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evt_any |-> (en && r_op == ostsb_pkg::OP_TICK && $onehot(evt_valid)))
        else $error("expiry event outside a tick walk");

    // a status beat always closes its item and carries no id
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == ostsb_pkg::KIND_STATUS) |-> (r_out_last && r_out_id == '0))
        else $error("status beat without last or with an id");

endmodule
